>>> hw/rtl/and_or_barrier_table_defines.svh
// Assertion macros for the barrier table checker
`ifndef AND_OR_BARRIER_TABLE_DEFINES_SVH
`define AND_OR_BARRIER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ABT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("barrier table check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define ABT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("barrier table check failed");

`endif

>>> hw/rtl/abt_pkg.sv
package abt_pkg;

    // Default sizes
    localparam int BARRIER_SLOTS_DEF = 16;
    localparam int WAITERS_DEF       = 16;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 64;
    localparam int TOTAL_W   = 8;
    localparam int ENTRY_W   = 64;
    localparam int STATUS_W  = 3;
    localparam int WTOTAL_W  = 5;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_REG_AND = 2'd0,
        KIND_REG_OR  = 2'd1,
        KIND_SIGNAL  = 2'd2
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_REGISTERED = 3'd0,
        ST_RELEASED   = 3'd1,
        ST_WAITING    = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_LIST_FULL  = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_RD,
        S_EMIT
    } t_state;

    // Key lookup outcome
    typedef struct packed {
        logic hit;
        logic has_free;
    } t_lookup;

endpackage

>>> hw/rtl/abt_if.sv
// Request channel
interface abt_req_if;
    logic                          valid;
    logic                          ready;
    logic [abt_pkg::KIND_W-1:0]    kind;
    logic [abt_pkg::KEY_W-1:0]     barrier_key;
    logic [abt_pkg::TOTAL_W-1:0]   stream_total;
    logic [abt_pkg::ENTRY_W-1:0]   entry_word;

    modport source (output valid, kind, barrier_key, stream_total, entry_word, input ready);
    modport sink   (input valid, kind, barrier_key, stream_total, entry_word, output ready);
endinterface

// Result channel
interface abt_res_if;
    logic                          valid;
    logic                          ready;
    logic [abt_pkg::STATUS_W-1:0]  status;
    logic [abt_pkg::ENTRY_W-1:0]   released_entry;
    logic                          last;
    logic                          is_triggered;
    logic [abt_pkg::WTOTAL_W-1:0]  waiter_total;

    modport source (output valid, status, released_entry, last, is_triggered, waiter_total,
                    input ready);
    modport sink   (input valid, status, released_entry, last, is_triggered, waiter_total,
                    output ready);
endinterface

>>> hw/rtl/abt_ram.sv
module abt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port holding its last data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/abt_cam.sv
module abt_cam #(
    parameter int SLOTS = abt_pkg::BARRIER_SLOTS_DEF,
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmp,
    input  logic [abt_pkg::KEY_W-1:0] i_key,
    input  logic                     i_alloc,
    output abt_pkg::t_lookup         o_lookup,
    output logic [SW-1:0]            o_slot
);

    import abt_pkg::*;

    logic [SLOTS-1:0] r_valid;
    logic [KEY_W-1:0] r_key [SLOTS];
    logic [KEY_W-1:0] r_cmp_key;
    logic [SLOTS-1:0] r_hit;
    logic [SLOTS-1:0] r_free;
    logic [SW-1:0]    hit_idx;
    logic [SW-1:0]    free_idx;

    // Valid bits: set on allocation, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_alloc) begin
            r_valid[free_idx] <= 1'b1;
        end
    end

    // Compare the requested key against every slot, capture the match vectors
    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_cmp_key <= i_key;
            for (int i = 0; i < SLOTS; i++) begin
                r_hit[i]  <= r_valid[i] && (r_key[i] == i_key);
                r_free[i] <= !r_valid[i];
            end
        end
        if (i_alloc) begin
            r_key[free_idx] <= r_cmp_key;
        end
    end

    // Pick the lowest matching slot and the lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hit_idx = SW'(i);
            end
            if (r_free[i]) begin
                free_idx = SW'(i);
            end
        end
    end

    assign o_lookup.hit      = |r_hit;
    assign o_lookup.has_free = |r_free;
    assign o_slot            = (|r_hit) ? hit_idx : free_idx;

endmodule

>>> hw/rtl/and_or_barrier_table.sv
// Barrier table with AND and OR barriers found by a 64-bit key. One request is in
// work at a time: a request steps through accept with the key compare across all
// slots, slot record read, then update and result; a signal that releases N
// waiting entries adds a waiter memory read and a result register load per
// entry. The update and each load wait while the output holds an untaken result.
// The slot record read-modify-write and the one waiter read port set this order.
// A finished result waits in an output register while the next request is taken.
// Slot valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module and_or_barrier_table #(
    parameter int BARRIER_SLOTS       = abt_pkg::BARRIER_SLOTS_DEF,
    parameter int WAITERS_PER_BARRIER = abt_pkg::WAITERS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    abt_req_if.sink   i_req,
    abt_res_if.source o_res
);

    import abt_pkg::*;

    localparam int SW = (BARRIER_SLOTS > 1) ? $clog2(BARRIER_SLOTS) : 1;
    localparam int CW = $clog2(WAITERS_PER_BARRIER + 1);
    localparam int IW = (WAITERS_PER_BARRIER > 1) ? $clog2(WAITERS_PER_BARRIER) : 1;
    localparam int WDEPTH = BARRIER_SLOTS * WAITERS_PER_BARRIER;
    localparam int AW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int MW = 2 + TOTAL_W + CW;

    t_state              r_state, n_state;
    logic [KIND_W-1:0]   r_kind;
    logic [TOTAL_W-1:0]  r_total;
    logic [ENTRY_W-1:0]  r_entry;
    logic [SW-1:0]       r_slot;
    logic                r_found;
    logic                r_alloc;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_idx;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [ENTRY_W-1:0]  r_out_entry;
    logic                r_out_last;
    logic                r_out_trig;
    logic [CW-1:0]       r_out_total;

    t_lookup             lookup;
    logic [SW-1:0]       cam_slot;
    logic                req_accept;
    logic                out_free;
    logic                look_alloc;
    logic                cam_cmp;
    logic                cam_alloc;
    logic                meta_re;
    logic                wait_re;
    logic                mod_go;
    logic                emit_go;
    logic                emit_last;

    logic [MW-1:0]       meta_rdata;
    logic [MW-1:0]       meta_wdata;
    logic                meta_we;
    logic [ENTRY_W-1:0]  wait_rdata;
    logic                wait_we;
    logic [AW-1:0]       wait_waddr;
    logic [AW-1:0]       wait_raddr;

    logic                m_mode, m_trig;
    logic [TOTAL_W-1:0]  m_rem;
    logic [CW-1:0]       m_cnt;
    logic                u_mode, u_trig;
    logic [TOTAL_W-1:0]  u_rem;
    logic [CW-1:0]       u_cnt;
    logic                mod_write;
    logic                mod_append;
    logic                mod_burst;
    t_status             mod_status;
    logic                mod_trig;
    logic [CW-1:0]       mod_total;

    // Key store and match
    abt_cam #(
        .SLOTS (BARRIER_SLOTS)
    ) u_cam (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmp    (cam_cmp),
        .i_key    (i_req.barrier_key),
        .i_alloc  (cam_alloc),
        .o_lookup (lookup),
        .o_slot   (cam_slot)
    );

    // Slot records: mode, triggered, remaining, waiter count
    abt_ram #(
        .WIDTH (MW),
        .DEPTH (BARRIER_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_slot),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (cam_slot),
        .o_rdata (meta_rdata)
    );

    // Waiting entry words, one row of waiters per slot
    abt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WDEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wait_we),
        .i_waddr (wait_waddr),
        .i_wdata (r_entry),
        .i_re    (wait_re),
        .i_raddr (wait_raddr),
        .o_rdata (wait_rdata)
    );

    assign out_free   = !r_out_valid || o_res.ready;
    assign req_accept = i_req.valid && i_req.ready;
    assign look_alloc = !lookup.hit && lookup.has_free &&
                        (r_kind == KIND_REG_AND || r_kind == KIND_REG_OR);
    assign emit_last  = ((r_idx + CW'(1)) == r_n);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (out_free) n_state = mod_burst ? S_RD : S_IDLE;
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = emit_last ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_req.ready = 1'b0;
        cam_cmp     = 1'b0;
        cam_alloc   = 1'b0;
        meta_re     = 1'b0;
        wait_re     = 1'b0;
        mod_go      = 1'b0;
        emit_go     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = i_rst_n;
                cam_cmp     = i_req.valid && i_rst_n;
            end
            S_LOOK: begin
                meta_re   = 1'b1;
                cam_alloc = look_alloc;
            end
            S_MOD: begin
                mod_go = out_free;
            end
            S_RD: begin
                wait_re = 1'b1;
            end
            S_EMIT: begin
                emit_go = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request and the lookup outcome
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_kind  <= i_req.kind;
            r_total <= i_req.stream_total;
            r_entry <= i_req.entry_word;
        end
        if (r_state == S_LOOK) begin
            r_slot  <= cam_slot;
            r_found <= lookup.hit;
            r_alloc <= look_alloc;
        end
        if (mod_go) begin
            r_n   <= m_cnt;
            r_idx <= '0;
        end else if (emit_go) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // Slot record as read, or the defaults of a freshly allocated slot
    always_comb begin
        if (r_alloc) begin
            m_mode = 1'b0;
            m_trig = 1'b0;
            m_rem  = '0;
            m_cnt  = '0;
        end else begin
            {m_mode, m_trig, m_rem, m_cnt} = meta_rdata;
        end
    end

    // Apply the request to the slot record
    always_comb begin
        u_mode     = m_mode;
        u_trig     = m_trig;
        u_rem      = m_rem;
        u_cnt      = m_cnt;
        mod_write  = 1'b0;
        mod_append = 1'b0;
        mod_burst  = 1'b0;
        mod_status = ST_UNKNOWN;
        mod_trig   = 1'b0;
        mod_total  = '0;
        case (r_kind) inside
            KIND_REG_AND, KIND_REG_OR: begin
                if (!r_found && !r_alloc) begin
                    mod_status = ST_TABLE_FULL;
                end else begin
                    mod_write = 1'b1;
                    if (r_kind == KIND_REG_AND) begin
                        if (m_rem == '0 && !m_trig) begin
                            u_rem  = r_total;
                            u_mode = 1'b1;
                        end
                    end else if (m_cnt == '0 && !m_trig) begin
                        u_mode = 1'b0;
                        u_rem  = '0;
                    end
                    mod_trig = m_trig;
                    if (m_cnt >= CW'(WAITERS_PER_BARRIER)) begin
                        mod_status = ST_LIST_FULL;
                        mod_total  = m_cnt;
                    end else begin
                        mod_append = 1'b1;
                        u_cnt      = m_cnt + CW'(1);
                        mod_status = ST_REGISTERED;
                        mod_total  = u_cnt;
                    end
                end
            end
            KIND_SIGNAL: begin
                if (!r_found) begin
                    mod_status = ST_UNKNOWN;
                end else if (m_trig) begin
                    mod_status = ST_UNKNOWN;
                    mod_trig   = 1'b1;
                    mod_total  = m_cnt;
                end else begin
                    mod_write = 1'b1;
                    mod_total = m_cnt;
                    if (m_mode && m_rem != '0) begin
                        u_rem = m_rem - TOTAL_W'(1);
                    end
                    if (m_mode && u_rem != '0) begin
                        mod_status = ST_WAITING;
                    end else begin
                        u_trig     = 1'b1;
                        mod_trig   = 1'b1;
                        mod_status = ST_RELEASED;
                        mod_burst  = (m_cnt != '0);
                    end
                end
            end
            default: begin
                mod_status = ST_UNKNOWN;
            end
        endcase
    end

    assign meta_wdata = {u_mode, u_trig, u_rem, u_cnt};
    assign meta_we    = mod_go && mod_write;
    assign wait_we    = mod_go && mod_append;
    assign wait_waddr = AW'(r_slot) * AW'(WAITERS_PER_BARRIER) + AW'(m_cnt[IW-1:0]);
    assign wait_raddr = AW'(r_slot) * AW'(WAITERS_PER_BARRIER) + AW'(r_idx[IW-1:0]);

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mod_go && !mod_burst) begin
            r_out_valid <= 1'b1;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mod_go && !mod_burst) begin
            r_out_status <= mod_status;
            r_out_entry  <= '0;
            r_out_last   <= 1'b1;
            r_out_trig   <= mod_trig;
            r_out_total  <= mod_total;
        end else if (emit_go) begin
            r_out_status <= ST_RELEASED;
            r_out_entry  <= wait_rdata;
            r_out_last   <= emit_last;
            r_out_trig   <= 1'b1;
            r_out_total  <= r_n;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.released_entry = r_out_entry;
    assign o_res.last           = r_out_last;
    assign o_res.is_triggered   = r_out_trig;
    assign o_res.waiter_total   = WTOTAL_W'(r_out_total);

endmodule

>>> hw/rtl/abt_checker.sv
`include "and_or_barrier_table_defines.svh"

module abt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            i_ready,
    input logic [abt_pkg::STATUS_W-1:0]    i_status,
    input logic [abt_pkg::ENTRY_W-1:0]     i_entry,
    input logic                            i_last,
    input logic                            i_trig
);

    import abt_pkg::*;

    // Only a release burst has results that are not last
    `ABT_ASSERT_NOW(a_burst_is_release, i_valid && !i_last, i_status == ST_RELEASED)

    // Only released results carry an entry word
    `ABT_ASSERT_NOW(a_entry_zero, i_valid && i_status != ST_RELEASED, i_entry == '0)

    // A release always shows the barrier as triggered
    `ABT_ASSERT_NOW(a_release_trig, i_valid && i_status == ST_RELEASED, i_trig)

    // A stalled result stays offered
    `ABT_ASSERT_NEXT(a_hold_valid, i_valid && !i_ready, i_valid)

endmodule

bind and_or_barrier_table abt_checker u_abt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_status (o_res.status),
    .i_entry  (o_res.released_entry),
    .i_last   (o_res.last),
    .i_trig   (o_res.is_triggered)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import abt_pkg::*;

    localparam int SLOTS       = BARRIER_SLOTS_DEF;
    localparam int WAITERS     = WAITERS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 90;

    // One expected result
    typedef struct {
        t_status               status;
        logic [ENTRY_W-1:0]    entry;
        logic                  is_last;
        logic                  fired;
        logic [WTOTAL_W-1:0]   waiting;
    } t_barrier_result;

    logic i_clk;
    logic i_rst_n;

    abt_req_if req_ch ();
    abt_res_if res_ch ();

    and_or_barrier_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Barrier table as the block should hold it
    logic                 bar_live   [SLOTS];
    logic [KEY_W-1:0]     bar_key    [SLOTS];
    logic                 bar_is_and [SLOTS];
    logic                 bar_fired  [SLOTS];
    logic [TOTAL_W-1:0]   bar_left   [SLOTS];
    int                   bar_count  [SLOTS];
    logic [ENTRY_W-1:0]   bar_parked [SLOTS][WAITERS];

    t_barrier_result      pending_results[$];
    logic [KEY_W-1:0]     known_keys[$];

    int  err_count;
    int  reqs_sent;
    int  cycle_count;
    bit  steady_source;
    bit  steady_sink;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Guard against a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int find_barrier(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (bar_live[i] && bar_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (bar_live[i])
                n++;
        return n;
    endfunction

    // Lowest free slot, fresh OR barrier with nothing waiting
    function automatic int claim_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++) begin
            if (!bar_live[i]) begin
                bar_live[i]   = 1'b1;
                bar_key[i]    = key;
                bar_is_and[i] = 1'b0;
                bar_fired[i]  = 1'b0;
                bar_left[i]   = '0;
                bar_count[i]  = 0;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = rand_word();
        while (find_barrier(k) >= 0)
            k = rand_word();
        return k;
    endfunction

    // Keep a key for later random traffic
    function automatic void remember_key(logic [KEY_W-1:0] key);
        known_keys.insert(known_keys.size(), key);
    endfunction

    function automatic void queue_result(t_status st, logic [ENTRY_W-1:0] e, bit lst,
                                         int s);
        t_barrier_result r;
        r.status  = st;
        r.entry   = e;
        r.is_last = lst;
        r.fired   = 1'b0;
        r.waiting = '0;
        if (s >= 0) begin
            r.fired   = bar_fired[s];
            r.waiting = WTOTAL_W'(bar_count[s]);
        end
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Update the table for one accepted request and queue what it must produce
    function automatic void apply_barrier_request(t_kind k, logic [KEY_W-1:0] key,
                                                  logic [TOTAL_W-1:0] total,
                                                  logic [ENTRY_W-1:0] entry);
        int s;
        int n;
        s = find_barrier(key);
        case (k)
            KIND_REG_AND, KIND_REG_OR: begin
                if (s < 0)
                    s = claim_slot(key);
                if (s < 0) begin
                    queue_result(ST_TABLE_FULL, '0, 1'b1, -1);
                    return;
                end
                // mode update happens even when the entry is dropped
                if (k == KIND_REG_AND) begin
                    if (bar_left[s] == 0 && !bar_fired[s]) begin
                        bar_left[s]   = total;
                        bar_is_and[s] = 1'b1;
                    end
                end else if (bar_count[s] == 0 && !bar_fired[s]) begin
                    bar_is_and[s] = 1'b0;
                    bar_left[s]   = '0;
                end
                if (bar_count[s] >= WAITERS) begin
                    queue_result(ST_LIST_FULL, '0, 1'b1, s);
                    return;
                end
                bar_parked[s][bar_count[s]] = entry;
                bar_count[s]++;
                queue_result(ST_REGISTERED, '0, 1'b1, s);
            end
            KIND_SIGNAL: begin
                if (s < 0) begin
                    queue_result(ST_UNKNOWN, '0, 1'b1, -1);
                    return;
                end
                if (bar_fired[s]) begin
                    queue_result(ST_UNKNOWN, '0, 1'b1, s);
                    return;
                end
                if (bar_is_and[s]) begin
                    if (bar_left[s] > 0)
                        bar_left[s]--;
                    if (bar_left[s] != 0) begin
                        queue_result(ST_WAITING, '0, 1'b1, s);
                        return;
                    end
                end
                // release: every parked entry in arrival order
                bar_fired[s] = 1'b1;
                n = (bar_count[s] > WAITERS) ? WAITERS : bar_count[s];
                if (n == 0)
                    queue_result(ST_RELEASED, '0, 1'b1, s);
                for (int i = 0; i < n; i++)
                    queue_result(ST_RELEASED, bar_parked[s][i], i + 1 == n, s);
            end
            default: queue_result(ST_UNKNOWN, '0, 1'b1, -1);
        endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        t_barrier_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d entry %h last %b trig %b wait %0d",
                     $time, res_ch.status, res_ch.released_entry, res_ch.last,
                     res_ch.is_triggered, res_ch.waiter_total);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            if (want.status !== res_ch.status || want.entry !== res_ch.released_entry ||
                want.is_last !== res_ch.last || want.fired !== res_ch.is_triggered ||
                want.waiting !== res_ch.waiter_total) begin
                $display("%0t: mismatch: expected status %0d entry %h last %b trig %b wait %0d",
                         $time, want.status, want.entry, want.is_last, want.fired,
                         want.waiting);
                $display("%0t:           actual status %0d entry %h last %b trig %b wait %0d",
                         $time, res_ch.status, res_ch.released_entry, res_ch.last,
                         res_ch.is_triggered, res_ch.waiter_total);
                err_count++;
            end
        end
    endtask

    // Result side: check each result, stall ready at random
    initial begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else begin
                if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                    check_result();
                    stall = steady_sink ? 0 : $urandom_range(0, 5);
                end else if (stall > 0) begin
                    stall--;
                end
                res_ch.ready <= (stall == 0);
            end
        end
    end

    // Send one request; valid stays high into the next request when no gap is drawn
    task automatic send_request(t_kind k, logic [KEY_W-1:0] key, logic [TOTAL_W-1:0] total,
                                logic [ENTRY_W-1:0] entry);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= k;
        req_ch.barrier_key  <= key;
        req_ch.stream_total <= total;
        req_ch.entry_word   <= entry;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        apply_barrier_request(k, key, total, entry);
        reqs_sent++;
        gap = steady_source ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the source until every expected result is in
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_signal(logic [KEY_W-1:0] key);
        send_request(KIND_SIGNAL, key, TOTAL_W'($urandom), rand_word());
    endtask

    // AND counting, extremes of the fields, signals to unknown and triggered barriers
    task automatic test_and_barrier();
        logic [KEY_W-1:0] k;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        send_request(KIND_REG_AND, '0, 8'hFF, '1);
        send_request(KIND_REG_OR, '0, 8'h00, '0);
        send_signal('0);
        send_request(KIND_REG_AND, '0, 8'h07, rand_word());
        send_signal('0);
        remember_key('0);

        send_signal('1);
        send_request(KIND_REG_OR, '1, 8'h00, rand_word());
        send_request(KIND_REG_AND, '1, 8'h00, rand_word());
        send_signal('1);
        send_signal('1);
        send_request(KIND_REG_AND, '1, 8'h03, rand_word());
        send_request(KIND_REG_OR, '1, 8'h00, rand_word());
        send_signal('1);
        remember_key('1);

        k = fresh_key();
        send_request(KIND_REG_AND, k, 8'h02, rand_word());
        send_signal(k);
        send_signal(k);
        remember_key(k);
        wait_for_results();
    endtask

    // OR release on first signal, and the switch of an OR barrier to AND
    task automatic test_or_barrier();
        logic [KEY_W-1:0] k;
        steady_source = 1'b1;
        steady_sink   = 1'b1;
        k = fresh_key();
        send_request(KIND_REG_OR, k, 8'h55, rand_word());
        send_request(KIND_REG_OR, k, 8'hAA, rand_word());
        send_signal(k);
        send_request(KIND_REG_OR, k, 8'h00, rand_word());
        remember_key(k);

        k = fresh_key();
        send_request(KIND_REG_OR, k, 8'h00, rand_word());
        send_request(KIND_REG_AND, k, 8'h02, rand_word());
        send_signal(k);
        send_signal(k);
        remember_key(k);
        wait_for_results();
    endtask

    // Fill one waiter list, overflow it, then release the full burst
    task automatic test_waiter_list_full();
        logic [KEY_W-1:0] k;
        steady_source = 1'b1;
        steady_sink   = 1'b0;
        k = fresh_key();
        for (int i = 0; i < WAITERS; i++)
            send_request(KIND_REG_OR, k, TOTAL_W'($urandom), rand_word());
        steady_source = 1'b0;
        send_request(KIND_REG_AND, k, 8'h02, rand_word());
        send_signal(k);
        send_signal(k);
        send_request(KIND_REG_OR, k, 8'h00, rand_word());
        remember_key(k);
        wait_for_results();
    endtask

    // Register a few entries on a new barrier and signal it until it releases
    task automatic run_barrier_round(logic [KEY_W-1:0] key);
        int nreg;
        int tries;
        int s;
        logic [TOTAL_W-1:0] total;
        nreg = $urandom_range(1, 8);
        for (int i = 0; i < nreg; i++) begin
            total = ($urandom_range(0, 9) == 0) ? TOTAL_W'($urandom)
                                                : TOTAL_W'($urandom_range(0, 4));
            send_request($urandom_range(0, 1) ? KIND_REG_AND : KIND_REG_OR, key, total,
                         rand_word());
        end
        tries = 0;
        s = find_barrier(key);
        while (!bar_fired[s] && tries < 8) begin
            send_signal(key);
            tries++;
        end
        // late traffic on the triggered barrier
        case ($urandom_range(0, 3))
            0: send_signal(key);
            1: send_request(KIND_REG_AND, key, TOTAL_W'($urandom), rand_word());
            default: ;
        endcase
    endtask

    // Well-formed barrier rounds, signals to unknown keys and random requests on known keys
    task automatic test_random_traffic();
        int start;
        logic [KEY_W-1:0] k;
        start = reqs_sent;
        while (reqs_sent - start < RANDOM_REQS) begin
            if ($urandom_range(0, 7) == 0) begin
                steady_source = ($urandom_range(0, 2) == 0);
                steady_sink   = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 19) == 0)
                wait_for_results();
            if (slots_in_use() < SLOTS - 1 && $urandom_range(0, 1) == 0) begin
                k = fresh_key();
                remember_key(k);
                run_barrier_round(k);
            end else if ($urandom_range(0, 9) < 2) begin
                send_signal(fresh_key());
            end else begin
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                send_request(t_kind'($urandom_range(0, 2)), k, TOTAL_W'($urandom),
                             rand_word());
            end
        end
        wait_for_results();
    endtask

    // Use up every slot, then register two new keys, signal an unknown one, reuse a known one
    task automatic test_table_full();
        logic [KEY_W-1:0] k;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        while (slots_in_use() < SLOTS) begin
            k = fresh_key();
            remember_key(k);
            send_request(KIND_REG_OR, k, 8'h00, rand_word());
        end
        send_request(KIND_REG_AND, fresh_key(), 8'h01, rand_word());
        send_request(KIND_REG_OR, fresh_key(), 8'h00, rand_word());
        send_signal(fresh_key());
        k = known_keys[known_keys.size() - 1];
        send_request(KIND_REG_AND, k, 8'h01, rand_word());
        send_signal(k);
        wait_for_results();
    endtask

    // Reset, then the tests in turn
    initial begin
        err_count     = 0;
        reqs_sent     = 0;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            bar_live[i] = 1'b0;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_REG_AND;
        req_ch.barrier_key  <= '0;
        req_ch.stream_total <= '0;
        req_ch.entry_word   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_and_barrier();
        test_or_barrier();
        test_waiter_list_full();
        test_random_traffic();
        test_table_full();

        // let any stray result show up before the verdict
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/abt_pkg.sv
hw/rtl/abt_if.sv
hw/rtl/abt_ram.sv
hw/rtl/abt_cam.sv
hw/rtl/and_or_barrier_table.sv
hw/rtl/abt_checker.sv
tb/tb.sv
